// File: src/mld_pkg.sv
package mld_pkg;

  // register map
  localparam int APB_ADDR_WIDTH = 3;
  localparam logic [APB_ADDR_WIDTH-1:0] ADDR_SENSITIVITY = 3'd0;
  localparam int APB_DATA_WIDTH = 32;

  localparam int SENS_WIDTH = 16;
  localparam logic [SENS_WIDTH-1:0] SENS_RESET = 16'd26;

  // field widths
  localparam int DIR_WIDTH   = 16;
  localparam int YAW_WIDTH   = 9;
  localparam int PITCH_WIDTH = 8;

  // CORDIC number formats: angle in radians Q2.30, vector Q2.30 with headroom
  localparam int ANGLE_WIDTH    = 33;
  localparam int VEC_WIDTH      = 34;
  localparam int TRIG_WIDTH     = 32;
  localparam int PROD_WIDTH     = 2 * TRIG_WIDTH;
  localparam int ATAN_ENTRIES   = 24;
  localparam int ATAN_IDX_WIDTH = 5;

  localparam logic signed [ANGLE_WIDTH-1:0] DEG_Q30  = 33'sd18740330;
  localparam logic signed [VEC_WIDTH-1:0]   GAIN_Q30 = 34'sd652032875;

  localparam int YAW_FULL = 360;
  localparam int YAW_HALF = 180;
  localparam int YAW_QTR  = 90;
  localparam int YAW_3QTR = 270;

  typedef logic signed [DIR_WIDTH-1:0]   dir_t;
  typedef logic        [YAW_WIDTH-1:0]   yaw_t;
  typedef logic signed [PITCH_WIDTH-1:0] pitch_t;
  typedef logic signed [TRIG_WIDTH-1:0]  trig_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;

  localparam dir_t DIR_MAX = 16'sh7fff;
  localparam dir_t DIR_MIN = 16'sh8000;

  // arctangent of 2^-i, radians Q2.30
  function automatic logic signed [ANGLE_WIDTH-1:0] atan_q30(
    input logic [ATAN_IDX_WIDTH-1:0] idx
  );
    logic signed [ANGLE_WIDTH-1:0] v;
    unique case (idx)
      5'd0:  v = 33'sd843314857;
      5'd1:  v = 33'sd497837830;
      5'd2:  v = 33'sd263043837;
      5'd3:  v = 33'sd133525159;
      5'd4:  v = 33'sd67021687;
      5'd5:  v = 33'sd33543516;
      5'd6:  v = 33'sd16775851;
      5'd7:  v = 33'sd8388437;
      5'd8:  v = 33'sd4194283;
      5'd9:  v = 33'sd2097149;
      5'd10: v = 33'sd1048576;
      5'd11: v = 33'sd524288;
      5'd12: v = 33'sd262144;
      5'd13: v = 33'sd131072;
      5'd14: v = 33'sd65536;
      5'd15: v = 33'sd32768;
      5'd16: v = 33'sd16384;
      5'd17: v = 33'sd8192;
      5'd18: v = 33'sd4096;
      5'd19: v = 33'sd2048;
      5'd20: v = 33'sd1024;
      5'd21: v = 33'sd512;
      5'd22: v = 33'sd256;
      5'd23: v = 33'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic dir_t sat_dir(input logic signed [PROD_WIDTH-46:0] v);
    dir_t r;
    if (v > (PROD_WIDTH-45)'(DIR_MAX)) r = DIR_MAX;
    else if (v < (PROD_WIDTH-45)'(DIR_MIN)) r = DIR_MIN;
    else r = v[DIR_WIDTH-1:0];
    return r;
  endfunction

  // Q2.30 x Q2.30 product to Q1.15, round half up, saturate
  function automatic dir_t round_prod(input prod_t p);
    prod_t s;
    s = p + (prod_t'(1) <<< 44);
    return sat_dir(s[PROD_WIDTH-1:45]);
  endfunction

  // single Q2.30 value to Q1.15, round half up, saturate
  function automatic dir_t round_single(input trig_t v);
    logic signed [TRIG_WIDTH:0] s;
    s = (TRIG_WIDTH+1)'(v) + (TRIG_WIDTH+1)'(17'sd16384);
    return sat_dir((PROD_WIDTH-45)'($signed(s[TRIG_WIDTH:15])));
  endfunction

endpackage

// File: src/mld_in_if.sv
interface mld_in_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] cursor_x;
  logic signed [COORD_WIDTH-1:0] cursor_y;

  modport source (output valid, output cursor_x, output cursor_y, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, output ready);
endinterface

// File: src/mld_out_if.sv
interface mld_out_if;
  logic            valid;
  logic            ready;
  mld_pkg::dir_t   dir_x;
  mld_pkg::dir_t   dir_y;
  mld_pkg::dir_t   dir_z;
  mld_pkg::yaw_t   yaw_degrees;
  mld_pkg::pitch_t pitch_degrees;

  modport source (output valid, output dir_x, output dir_y, output dir_z,
                  output yaw_degrees, output pitch_degrees, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z,
                input yaw_degrees, input pitch_degrees, output ready);
endinterface

// File: src/mld_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle.
module mld_cordic #(
  parameter int STEPS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mld_pkg::pitch_t angle,   // whole degrees, within +/-90
  output logic            done,
  output mld_pkg::trig_t  cos_q30,
  output mld_pkg::trig_t  sin_q30
);
  import mld_pkg::*;

  localparam int IW = $clog2(STEPS);

  logic signed [VEC_WIDTH-1:0]   x, y, x_sh, y_sh;
  logic signed [ANGLE_WIDTH-1:0] z, atan_v;
  logic [IW-1:0]                 step;
  logic                          running;

  assign x_sh    = x >>> step;
  assign y_sh    = y >>> step;
  assign atan_v  = atan_q30(ATAN_IDX_WIDTH'(step));
  assign cos_q30 = x[TRIG_WIDTH-1:0];
  assign sin_q30 = y[TRIG_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
        x       <= GAIN_Q30;
        y       <= '0;
        z       <= ANGLE_WIDTH'(angle) * DEG_Q30;
      end else if (running) begin
        if (z >= 0) begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - atan_v;
        end else begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + atan_v;
        end
        if (step == IW'(STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule

// File: src/mouse_look_direction_unit.sv
// Mouse-look view direction. Each cursor position taken on the cursor channel is
// differenced against the previous one (x: new minus old, y: old minus new), scaled
// by the Q8.8 sensitivity register and truncated toward zero to whole degrees.
// The x term is added to the yaw, kept in 0..359 by a modulo-360 reduction; the
// y term is added to the pitch, clamped at +/-PITCH_LIMIT. One view item then
// carries the unit vector (cos yaw cos pitch, sin pitch, sin yaw cos pitch) in
// Q1.15, within 2 LSB, plus the new yaw and pitch. The first item after reset is
// differenced against the origin. One item is processed at a time; the next
// cursor item can be taken in the cycle after the view item is registered,
// and a finished item waits while the view output register still holds an
// untaken one. The cost is set by one shared CORDIC unit run twice, once per
// angle, at one micro-rotation per cycle, with a start and a handover per run.
// The modulo-360 reduction is a reciprocal multiplication, a multiply-back
// and one final compare-and-subtract. The cursor channel takes a new item
// once the previous one has reached the view output register, even if that
// result has not yet been taken.
// Sensitivity sits at byte address 0 of the APB port; it resets to 26 (about
// 0.1 degree per count). The user must write it only while the block is idle;
// the block itself does not enforce this.
module mouse_look_direction_unit #(
  parameter int COORD_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16,
  parameter int PITCH_LIMIT  = 89
) (
  input  logic                                 clk,
  input  logic                                 rst,
  mld_in_if.sink                               cursor,
  mld_out_if.source                            view,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mld_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [mld_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [mld_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                 pready
);
  import mld_pkg::*;

  // widths of the delta / scale / accumulate path
  localparam int DW      = COORD_WIDTH + 1;           // delta
  localparam int PW      = DW + SENS_WIDTH + 1;       // delta * sensitivity
  localparam int SW      = PW - 8;                    // whole degrees
  localparam int TW      = SW + 1;                    // accumulator sum

  localparam logic signed [PW-1:0] TRUNC_BIAS = PW'(255);
  localparam logic signed [TW-1:0] P_MAX      = TW'(PITCH_LIMIT);
  localparam logic signed [TW-1:0] P_MIN      = -P_MAX;
  localparam logic [TW-1:0]        YAW_FULL_W = TW'(YAW_FULL);
  // floor(2^TW / 360): quotient estimate is exact or one short for |sum| < 2^TW
  localparam logic [TW-1:0]        YAW_RECIP  = TW'((64'd1 << TW) / YAW_FULL);

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_TRUNC, S_ACC, S_ABS, S_QUOT, S_MOD, S_WRAP, S_FOLD,
    S_YAW, S_PITCH, S_MULX, S_MULZ, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [SENS_WIDTH-1:0] sensitivity;
  logic signed [SENS_WIDTH:0] sens_s;

  // architectural state
  logic signed [COORD_WIDTH-1:0] last_x, last_y;
  yaw_t   yaw_acc;
  pitch_t pitch_acc;

  // working registers
  logic signed [DW-1:0] dx, dy;
  logic signed [PW-1:0] px, py, px_adj, py_adj;
  logic signed [SW-1:0] sx, sy;
  logic signed [TW-1:0] yaw_sum, pitch_sum, pitch_sat;
  logic                 yaw_neg;
  logic [TW-1:0]        rem, rem_fix, quot;
  logic [2*TW-1:0]      recip_prod;

  // angle fold and CORDIC
  logic signed [YAW_WIDTH:0] yaw_s, ry;
  logic   fold_neg, fold_neg_next;
  pitch_t ry_next;
  logic   cstart, cdone;
  pitch_t cangle;
  trig_t  ccos, csin;
  trig_t  cyaw, syaw, cp, sp;

  // shared product multiplier
  trig_t mul_a;
  prod_t prod;
  dir_t  dir_x_hold;

  // view output register
  logic   out_valid;
  dir_t   out_x, out_y, out_z;
  yaw_t   out_yaw;
  pitch_t out_pitch;
  logic   out_free;

  mld_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cstart),
    .angle   (cangle),
    .done    (cdone),
    .cos_q30 (ccos),
    .sin_q30 (csin)
  );

  // APB: single register, no wait states
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SENSITIVITY) ? APB_DATA_WIDTH'(sensitivity) : '0;
  assign sens_s = {1'b0, sensitivity};

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity <= SENS_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_SENSITIVITY) begin
      sensitivity <= pwdata[SENS_WIDTH-1:0];
    end
  end

  // truncate toward zero: bias negatives by 255 before the shift
  assign px_adj = px[PW-1] ? px + TRUNC_BIAS : px;
  assign py_adj = py[PW-1] ? py + TRUNC_BIAS : py;

  assign pitch_sum = TW'(sy) + TW'(pitch_acc);
  always_comb begin
    priority if (pitch_sum > P_MAX) pitch_sat = P_MAX;
    else if (pitch_sum < P_MIN) pitch_sat = P_MIN;
    else pitch_sat = pitch_sum;
  end

  // |sum| / 360 by reciprocal; the remainder left over is below 720
  assign recip_prod = (2*TW)'(rem) * (2*TW)'(YAW_RECIP);
  assign rem_fix    = (rem >= YAW_FULL_W) ? rem - YAW_FULL_W : rem;

  // fold yaw into +/-90 degrees; middle band is shifted by 180 and negated
  assign yaw_s = $signed({1'b0, yaw_acc});
  always_comb begin
    priority if (yaw_s > (YAW_WIDTH+1)'(YAW_QTR) && yaw_s < (YAW_WIDTH+1)'(YAW_3QTR)) begin
      ry            = yaw_s - (YAW_WIDTH+1)'(YAW_HALF);
      fold_neg_next = 1'b1;
    end else if (yaw_s >= (YAW_WIDTH+1)'(YAW_3QTR)) begin
      ry            = yaw_s - (YAW_WIDTH+1)'(YAW_FULL);
      fold_neg_next = 1'b0;
    end else begin
      ry            = yaw_s;
      fold_neg_next = 1'b0;
    end
  end
  assign ry_next = ry[PITCH_WIDTH-1:0];

  assign mul_a    = (state == S_MULX) ? cyaw : syaw;
  assign out_free = !out_valid || view.ready;

  assign cursor.ready = (state == S_IDLE);

  assign view.valid         = out_valid;
  assign view.dir_x         = out_x;
  assign view.dir_y         = out_y;
  assign view.dir_z         = out_z;
  assign view.yaw_degrees   = out_yaw;
  assign view.pitch_degrees = out_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_x    <= '0;
      last_y    <= '0;
      yaw_acc   <= '0;
      pitch_acc <= '0;
      cstart    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // one start pulse per angle: yaw from the fold, pitch once yaw is done
      cstart <= (state == S_FOLD) || (state == S_YAW && cdone);
      if (out_valid && view.ready && state != S_OUT) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (cursor.valid) begin
            dx     <= DW'(cursor.cursor_x) - DW'(last_x);
            dy     <= DW'(last_y) - DW'(cursor.cursor_y);
            last_x <= cursor.cursor_x;
            last_y <= cursor.cursor_y;
            state  <= S_SCALE;
          end
        end
        S_SCALE: begin
          px    <= dx * sens_s;
          py    <= dy * sens_s;
          state <= S_TRUNC;
        end
        S_TRUNC: begin
          sx    <= px_adj[PW-1:8];
          sy    <= py_adj[PW-1:8];
          state <= S_ACC;
        end
        S_ACC: begin
          yaw_sum   <= TW'(sx) + TW'($signed({1'b0, yaw_acc}));
          pitch_acc <= pitch_sat[PITCH_WIDTH-1:0];
          state     <= S_ABS;
        end
        S_ABS: begin
          yaw_neg <= yaw_sum[TW-1];
          rem     <= yaw_sum[TW-1] ? TW'(-yaw_sum) : TW'(yaw_sum);
          state   <= S_QUOT;
        end
        S_QUOT: begin
          quot  <= recip_prod[2*TW-1:TW];
          state <= S_MOD;
        end
        S_MOD: begin
          rem   <= rem - quot * YAW_FULL_W;
          state <= S_WRAP;
        end
        S_WRAP: begin
          // C-style remainder of a negative sum, then lifted into 0..359
          if (yaw_neg && rem_fix != '0) begin
            yaw_acc <= YAW_WIDTH'(YAW_FULL) - rem_fix[YAW_WIDTH-1:0];
          end else begin
            yaw_acc <= rem_fix[YAW_WIDTH-1:0];
          end
          state <= S_FOLD;
        end
        S_FOLD: begin
          fold_neg <= fold_neg_next;
          cangle   <= ry_next;
          state    <= S_YAW;
        end
        S_YAW: begin
          if (cdone) begin
            cyaw   <= fold_neg ? -ccos : ccos;
            syaw   <= fold_neg ? -csin : csin;
            cangle <= pitch_acc;
            state  <= S_PITCH;
          end
        end
        S_PITCH: begin
          if (cdone) begin
            cp    <= ccos;
            sp    <= csin;
            state <= S_MULX;
          end
        end
        S_MULX: begin
          prod  <= mul_a * cp;
          state <= S_MULZ;
        end
        S_MULZ: begin
          dir_x_hold <= round_prod(prod);
          prod       <= mul_a * cp;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_x     <= dir_x_hold;
            out_y     <= round_single(sp);
            out_z     <= round_prod(prod);
            out_yaw   <= yaw_acc;
            out_pitch <= pitch_acc;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sim/mouse_look_direction_checker.sv
`timescale 1ns / 100ps

module mouse_look_direction_checker
  import mld_pkg::*;
#(
  parameter int PITCH_LIMIT  = 89,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  mld_in_if                         cursor,
  mld_out_if                        view,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  input  logic [APB_DATA_WIDTH-1:0] prdata,
  input  logic                      pready,
  output int                        fail_count,
  output int                        pending
);

  localparam longint ONE_DEGREE_Q30  = 64'sd18740330;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032875;
  localparam longint PROD_ROUND      = 64'sd17592186044416;  // half LSB at bit 45
  localparam longint TRIG_ROUND      = 64'sd16384;           // half LSB at bit 15
  localparam int     PRINT_CAP       = 30;

  typedef struct packed {
    dir_t   dir_x;
    dir_t   dir_y;
    dir_t   dir_z;
    yaw_t   yaw;
    pitch_t pitch;
  } view_t;

  view_t                 expected_views[$];
  logic [SENS_WIDTH-1:0] sensitivity;
  longint                last_x, last_y, yaw_acc, pitch_acc;
  int                    views_seen;

  initial begin
    fail_count = 0;
    pending    = 0;
    views_seen = 0;
  end

  task automatic report(input string msg);
    if (fail_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input longint got, input longint want);
    if (got != want)
      report($sformatf("view item %0d %s: got %0d, expected %0d", views_seen, name, got,
                       want));
  endtask

  function automatic longint arctan_q30(input int i);
    longint v;
    case (i)
      0:  v = 843314857;
      1:  v = 497837830;
      2:  v = 263043837;
      3:  v = 133525159;
      4:  v = 67021687;
      5:  v = 33543516;
      6:  v = 16775851;
      7:  v = 8388437;
      8:  v = 4194283;
      9:  v = 2097149;
      10: v = 1048576;
      11: v = 524288;
      12: v = 262144;
      13: v = 131072;
      14: v = 65536;
      15: v = 32768;
      16: v = 16384;
      17: v = 8192;
      18: v = 4096;
      19: v = 2048;
      20: v = 1024;
      21: v = 512;
      22: v = 256;
      23: v = 128;
      default: v = 0;
    endcase
    return v;
  endfunction

  // rotation-mode CORDIC, angle in whole degrees within +/-90
  function automatic void rotate(input longint deg, output longint c, output longint s);
    longint x, y, z, t;
    x = CORDIC_GAIN_Q30;
    y = 0;
    z = deg * ONE_DEGREE_Q30;
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan_q30(i);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan_q30(i);
      end
      x = t;
    end
    c = x;
    s = y;
  endfunction

  function automatic dir_t clip_q15(input longint v);
    if (v > 32767) return DIR_MAX;
    if (v < -32768) return DIR_MIN;
    return dir_t'(v);
  endfunction

  // moves the look angles by one cursor position and returns the new view
  function automatic view_t advance_view(input logic signed [15:0] cx,
                                         input logic signed [15:0] cy);
    longint dx, dy, sx, sy, yaw, pitch, ry, cyw, syw, cp, sp;
    bit     flip;
    view_t  v;
    dx = longint'(cx) - last_x;
    dy = last_y - longint'(cy);
    sx = (dx * longint'(sensitivity)) / 256;  // truncates toward zero
    sy = (dy * longint'(sensitivity)) / 256;
    last_x = longint'(cx);
    last_y = longint'(cy);

    yaw = (yaw_acc + sx) % YAW_FULL;
    if (yaw < 0) yaw = yaw + YAW_FULL;
    pitch = pitch_acc + sy;
    if (pitch > PITCH_LIMIT) pitch = PITCH_LIMIT;
    if (pitch < -PITCH_LIMIT) pitch = -PITCH_LIMIT;
    yaw_acc   = yaw;
    pitch_acc = pitch;

    // fold yaw into +/-90
    ry   = yaw;
    flip = 1'b0;
    if (ry > YAW_QTR && ry < YAW_3QTR) begin
      ry   = ry - YAW_HALF;
      flip = 1'b1;
    end else if (ry >= YAW_3QTR) begin
      ry = ry - YAW_FULL;
    end
    rotate(ry, cyw, syw);
    if (flip) begin
      cyw = -cyw;
      syw = -syw;
    end
    rotate(pitch, cp, sp);

    v.dir_x = clip_q15((cyw * cp + PROD_ROUND) >>> 45);
    v.dir_y = clip_q15((sp + TRIG_ROUND) >>> 15);
    v.dir_z = clip_q15((syw * cp + PROD_ROUND) >>> 45);
    v.yaw   = yaw_t'(yaw);
    v.pitch = pitch_t'(pitch);
    return v;
  endfunction

  always @(posedge clk) begin
    view_t got, want;
    if (rst) begin
      sensitivity = SENS_RESET;
      last_x      = 0;
      last_y      = 0;
      yaw_acc     = 0;
      pitch_acc   = 0;
      expected_views.delete();
    end else begin
      // result side first: an item taken at this edge cannot already be out
      if (view.valid && view.ready) begin
        views_seen++;
        got.dir_x = view.dir_x;
        got.dir_y = view.dir_y;
        got.dir_z = view.dir_z;
        got.yaw   = view.yaw_degrees;
        got.pitch = view.pitch_degrees;
        if (expected_views.size() == 0) begin
          report($sformatf("view item %0d arrived with none expected", views_seen));
        end else begin
          want = expected_views.pop_front();
          compare_field("dir_x", got.dir_x, want.dir_x);
          compare_field("dir_y", got.dir_y, want.dir_y);
          compare_field("dir_z", got.dir_z, want.dir_z);
          compare_field("yaw_degrees", got.yaw, want.yaw);
          compare_field("pitch_degrees", got.pitch, want.pitch);
        end
      end
      if (cursor.valid && cursor.ready)
        expected_views.push_back(advance_view(cursor.cursor_x, cursor.cursor_y));
      if (psel && penable && pready && paddr == ADDR_SENSITIVITY) begin
        if (pwrite)
          sensitivity = pwdata[SENS_WIDTH-1:0];
        else if (prdata !== APB_DATA_WIDTH'(sensitivity))
          report($sformatf("sensitivity read: got %0d, expected %0d", prdata, sensitivity));
      end
    end
    pending = expected_views.size();
  end

endmodule

// File: sim/mouse_look_direction_unit_tb.sv
`timescale 1ns / 100ps

module mouse_look_direction_unit_tb;
  import mld_pkg::*;

  localparam int ITEMS_PER_PHASE = 185;
  localparam int PHASES          = 10;
  localparam int TIMEOUT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES   = 70;       // a little over one item's latency
  localparam int RESET_CYCLES    = 9;

  localparam logic APB_READ  = 1'b0;
  localparam logic APB_WRITE = 1'b1;
  // no register lives here; writes must be dropped
  localparam logic [APB_ADDR_WIDTH-1:0] ADDR_UNMAPPED = 3'd4;

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  int          fail_count;
  int          pending;
  int          stall_left;
  longint      cycles;
  bit          steady;          // set for phases that run without any idling
  logic signed [15:0] last_x;   // last cursor position sent, for small moves
  logic signed [15:0] last_y;

  mld_in_if #(.COORD_WIDTH(16)) cursor_ch ();
  mld_out_if                    view_ch ();

  mouse_look_direction_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .cursor  (cursor_ch),
    .view    (view_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // watches both channels and the register port, predicts each view item
  mouse_look_direction_checker view_check (
    .clk        (clk),
    .rst        (rst),
    .cursor     (cursor_ch),
    .view       (view_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost item ends up here
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly short idles, now and then a long one; none in steady phases
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // view sink: random stalls of ready, one assignment per falling edge
  initial begin
    view_ch.ready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        view_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        view_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        view_ch.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // one APB transfer: setup cycle, then access until pready
  task automatic apb_access(input logic write, input logic [APB_ADDR_WIDTH-1:0] addr,
                            input logic [APB_DATA_WIDTH-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write then read back; the checker compares the read data
  task automatic set_sensitivity(input logic [SENS_WIDTH-1:0] value);
    apb_access(APB_WRITE, ADDR_SENSITIVITY, APB_DATA_WIDTH'(value));
    apb_access(APB_READ, ADDR_SENSITIVITY, '0);
  endtask

  // offer one cursor item after a random gap and hold it until taken
  task automatic send_cursor(input logic signed [15:0] x, input logic signed [15:0] y);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      cursor_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cursor_ch.valid    <= 1'b1;
    cursor_ch.cursor_x <= x;
    cursor_ch.cursor_y <= y;
    do @(posedge clk); while (!cursor_ch.ready);
    last_x = x;
    last_y = y;
  endtask

  // drop valid and wait for every predicted view item to come back
  task automatic drain();
    @(negedge clk);
    cursor_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    int                 r;
    logic signed [15:0] nx, ny;
    logic [15:0]        sens;

    rst                = 1'b1;
    cursor_ch.valid    = 1'b0;
    cursor_ch.cursor_x = '0;
    cursor_ch.cursor_y = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    steady             = 1'b0;
    last_x             = '0;
    last_y             = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // reset value of the sensitivity, first deltas taken against the origin;
    // small deltas check truncation toward zero in both directions
    apb_access(APB_READ, ADDR_SENSITIVITY, '0);
    send_cursor(16'sd10, -16'sd10);
    send_cursor(-16'sd10, 16'sd10);
    send_cursor(16'sd0, 16'sd0);
    drain();

    // unit sensitivity: one count per degree, so yaw can be walked over the
    // fold points (90, 270), the wrap at 360 and below zero, and pitch
    // driven into both clamps
    set_sensitivity(16'd256);
    apb_access(APB_WRITE, ADDR_UNMAPPED, 32'h0000_ffff);
    apb_access(APB_READ, ADDR_SENSITIVITY, '0);
    send_cursor(16'sd90, 16'sd0);
    send_cursor(16'sd91, 16'sd0);
    send_cursor(16'sd180, -16'sd100);
    send_cursor(16'sd269, -16'sd100);
    send_cursor(16'sd270, 16'sd100);
    send_cursor(16'sd359, 16'sd100);
    send_cursor(16'sd360, 16'sd0);
    send_cursor(-16'sd1, 16'sd0);
    drain();

    // largest sensitivity with full-scale jumps: huge wraps and clamps
    set_sensitivity(16'hffff);
    send_cursor(16'sh7fff, 16'sh8000);
    send_cursor(16'sh8000, 16'sh7fff);
    send_cursor(16'sh7fff, 16'sh7fff);
    send_cursor(16'sh8000, 16'sh8000);
    send_cursor(-16'sd32767, 16'sd1);
    drain();

    // zero sensitivity: angles must stand still
    set_sensitivity(16'd0);
    send_cursor(16'sd12345, -16'sd12345);
    send_cursor(16'sd0, 16'sd0);
    drain();

    // --- random part ---
    // each phase picks a sensitivity, every third runs with no idling at all
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       sens = 16'd26;
        1:       sens = 16'd256;
        2:       sens = 16'hffff;
        3:       sens = 16'd1;
        4:       sens = 16'($urandom);
        5:       sens = 16'd0;
        6:       sens = 16'd128;
        7:       sens = 16'($urandom_range(1, 600));
        8:       sens = 16'd4096;
        default: sens = 16'($urandom);
      endcase
      set_sensitivity(sens);
      steady = (p % 3 == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // ordinary mouse motion: a few counts either way
          nx = last_x + 16'($urandom_range(0, 48)) - 16'sd24;
          ny = last_y + 16'($urandom_range(0, 48)) - 16'sd24;
        end else if (r < 85) begin
          nx = last_x + 16'($urandom_range(0, 4096)) - 16'sd2048;
          ny = last_y + 16'($urandom_range(0, 4096)) - 16'sd2048;
        end else begin
          // jump anywhere; covers every coordinate bit
          nx = 16'($urandom);
          ny = 16'($urandom);
        end
        send_cursor(nx, ny);
      end
      drain();
    end
    steady = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
